>>> sv/bre_pkg.sv
// Shared types and constants for the bitmap range engine.
// Depends on nothing; used by bre_word_op and bitmap_range_engine.
package bre_pkg;

  localparam int unsigned MAP_BITS_DEF  = 4096;
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned FIRST_W       = 12;
  localparam int unsigned COUNT_W       = 13;
  localparam int unsigned LIMIT_W       = 14;

  typedef enum logic [1:0] {
    MODE_SET        = 2'd0,
    MODE_CLEAR      = 2'd1,
    MODE_TEST_SET   = 2'd2,
    MODE_TEST_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [FIRST_W-1:0]   first_bit;
    logic [COUNT_W-1:0]   bit_count;
  } req_t;

  typedef struct packed {
    logic test_true;
    logic range_error;
  } rsp_t;

  // Per-word control handed to the word operator.
  typedef struct packed {
    mode_e mode;
    logic  is_first;
    logic  is_last;
  } word_ctl_t;

endpackage

>>> sv/bitmap_range_engine.sv
// Allocation bitmap with range set, clear and test requests.
// Depends on bre_pkg and bre_word_op.
//
//   Channel   Direction  Handshake                Payload
//   in        input      in_valid_i / in_ready_o   in_req_i  (bre_pkg::req_t)
//   out       output     out_valid_o / out_ready_i out_rsp_o (bre_pkg::rsp_t)
//
// After reset the engine sweeps the bitmap store, writing one zero word per
// cycle, until all MAP_BITS / WORD_BITS words (64 at the defaults) are cleared; then in_ready_o rises.
// A request is taken in S_IDLE, reads its words in S_RUN, writes its last word
// in S_DRAIN and hands its result over in S_FIN; the store's single
// read-modify-write loop visits one word per cycle.
// An empty or out-of-range request goes straight to S_FIN and touches no word.
// The result sits in an output register, so a stalled consumer does not stop
// the next request from being taken; only the following result waits for it.
module bitmap_range_engine #(
  parameter int unsigned MAP_BITS  = bre_pkg::MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = bre_pkg::WORD_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bre_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bre_pkg::rsp_t out_rsp_o
);

  // MAP_BITS and WORD_BITS are powers of two; the map holds whole words.
  localparam int unsigned NUM_WORDS = MAP_BITS / WORD_BITS;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned LW        = $clog2(WORD_BITS);
  localparam int unsigned LIMIT_W   = bre_pkg::LIMIT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;  // reset sweep of the store
  localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a request
  localparam logic [2:0] S_RUN   = 3'd2;  // issuing word reads
  localparam logic [2:0] S_DRAIN = 3'd3;  // last word in the write stage
  localparam logic [2:0] S_FIN   = 3'd4;  // result ready for the output register

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic                 s1_v_q, s1_v_d;
  logic [AW-1:0]        s1_addr_q;
  logic                 fail_q, fail_d;
  logic                 ans_q, ans_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  bre_pkg::rsp_t        out_rsp_q;

  bre_pkg::mode_e       mode_q;
  logic [AW-1:0]        first_word_q, last_word_q;
  logic [LW-1:0]        lo_q, hi_q;

  logic [WORD_BITS-1:0] bit_store_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [LIMIT_W-1:0]   limit;
  logic [LIMIT_W-1:0]   last_bit;
  logic                 range_bad;
  logic                 empty_range;
  logic                 is_test;
  logic                 in_xfer;
  logic                 out_load;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  bre_pkg::word_ctl_t   word_ctl;
  logic [WORD_BITS-1:0] op_wdata;
  logic                 op_fail;

  // Range decode of the incoming request.
  assign limit       = LIMIT_W'(in_req_i.first_bit) + LIMIT_W'(in_req_i.bit_count);
  assign last_bit    = limit - LIMIT_W'(1);
  assign range_bad   = 32'(limit) > MAP_BITS;
  assign empty_range = (in_req_i.bit_count == '0);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_test    = (mode_q == bre_pkg::MODE_TEST_SET) ||
                      (mode_q == bre_pkg::MODE_TEST_CLEAR);

  // The output register takes a new result once its previous one is gone.
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Write stage: the word read in the previous cycle is modified here.
  assign word_ctl.mode     = mode_q;
  assign word_ctl.is_first = (s1_addr_q == first_word_q);
  assign word_ctl.is_last  = (s1_addr_q == last_word_q);

  bre_word_op #(
    .WORD_BITS(WORD_BITS),
    .LW       (LW)
  ) u_word_op (
    .rdata_i(rdata_q),
    .ctl_i  (word_ctl),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .wdata_o(op_wdata),
    .fail_o (op_fail)
  );

  // The reset sweep and the write stage share the single write port. Reads
  // issued in S_RUN always target a word other than the one being written, and a
  // request starts reading only after the previous one has written its last word.
  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_v_q && !is_test;
      mem_waddr = s1_addr_q;
      mem_wdata = op_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bit_store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= bit_store_q[rd_addr_q];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    rd_addr_d   = rd_addr_q;
    s1_v_d      = 1'b0;
    fail_d      = fail_q;
    ans_d       = ans_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // A test fails as soon as any word of the range disagrees.
    if (s1_v_q && op_fail) begin
      fail_d = 1'b1;
    end

    unique case (state_q)
      S_CLEAR: begin
        rd_addr_d = rd_addr_q + AW'(1);
        if (rd_addr_q == AW'(NUM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          fail_d = 1'b0;
          err_d  = range_bad;
          if (range_bad) begin
            ans_d   = 1'b0;
            state_d = S_FIN;
          end else if (empty_range) begin
            // Both tests hold on an empty range; updates answer zero.
            ans_d   = (in_req_i.mode == bre_pkg::MODE_TEST_SET) ||
                      (in_req_i.mode == bre_pkg::MODE_TEST_CLEAR);
            state_d = S_FIN;
          end else begin
            rd_addr_d = AW'(32'(in_req_i.first_bit) >> LW);
            state_d   = S_RUN;
          end
        end
      end
      S_RUN: begin
        s1_v_d = 1'b1;
        if (rd_addr_q == last_word_q) begin
          state_d = S_DRAIN;
        end else begin
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      S_DRAIN: begin
        ans_d   = is_test && !(fail_q || (s1_v_q && op_fail));
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rd_addr_q   <= '0;
      s1_v_q      <= 1'b0;
      fail_q      <= 1'b0;
      ans_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      s1_v_q      <= s1_v_d;
      fail_q      <= fail_d;
      ans_q       <= ans_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q       <= in_req_i.mode;
      first_word_q <= AW'(32'(in_req_i.first_bit) >> LW);
      last_word_q  <= AW'(32'(last_bit) >> LW);
      lo_q         <= in_req_i.first_bit[LW-1:0];
      hi_q         <= last_bit[LW-1:0];
    end
    s1_addr_q <= rd_addr_q;
    if (out_load) begin
      out_rsp_q.test_true   <= ans_q;
      out_rsp_q.range_error <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The store is written only by the reset sweep or by an update in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) || (state_q == S_FIN) |-> !mem_we)
    else $error("bitmap store written while no request is active");

  // The read pointer never runs past the last word of the range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (rd_addr_q <= last_word_q))
    else $error("word read beyond the end of the range");

  // A rejected range never reports a true test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.range_error |-> !out_rsp_o.test_true)
    else $error("range error reported with a true test answer");

  // The write stage only ever sees words of the current range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_addr_q >= first_word_q) && (s1_addr_q <= last_word_q))
    else $error("write stage holds a word outside the range");

endmodule

>>> sv/bre_word_op.sv
// Masks one bitmap word to the requested range and applies the operation.
// Depends on bre_pkg.
module bre_word_op #(
  parameter int unsigned WORD_BITS = bre_pkg::WORD_BITS_DEF,
  parameter int unsigned LW        = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] rdata_i,
  input  bre_pkg::word_ctl_t   ctl_i,
  input  logic [LW-1:0]        lo_i,
  input  logic [LW-1:0]        hi_i,
  output logic [WORD_BITS-1:0] wdata_o,
  output logic                 fail_o
);

  logic [LW-1:0]        lo_eff;
  logic [LW-1:0]        hi_eff;
  logic [LW-1:0]        top_gap;
  logic [WORD_BITS-1:0] mask;

  // Inner words of a range are fully covered; only the end words are partial.
  assign lo_eff  = ctl_i.is_first ? lo_i : '0;
  assign hi_eff  = ctl_i.is_last ? hi_i : LW'(WORD_BITS - 1);
  assign top_gap = LW'(WORD_BITS - 1) - hi_eff;
  assign mask    = ({WORD_BITS{1'b1}} << lo_eff) & ({WORD_BITS{1'b1}} >> top_gap);

  always_comb begin
    wdata_o = rdata_i;
    fail_o  = 1'b0;
    unique case (ctl_i.mode)
      bre_pkg::MODE_SET:        wdata_o = rdata_i | mask;
      bre_pkg::MODE_CLEAR:      wdata_o = rdata_i & ~mask;
      bre_pkg::MODE_TEST_SET:   fail_o  = |(~rdata_i & mask);
      bre_pkg::MODE_TEST_CLEAR: fail_o  = |(rdata_i & mask);
      default:                  fail_o  = 1'b0;
    endcase
  end

endmodule

>>> dv/tb.sv
// Self-checking testbench for bitmap_range_engine: directed table plus random traffic.
// Depends on bre_pkg and the engine RTL; keeps its own copy of the bitmap to
// predict each response.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_N      = bre_pkg::MAP_BITS_DEF;
  localparam int unsigned WORD_N     = bre_pkg::WORD_BITS_DEF;
  localparam int unsigned RAND_ITEMS = 1300;
  // The limit lies several times above the slowest legal run: full-map requests,
  // the longest sender gaps and a long receiver stall behind every request.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Settle time after the last response: one full-map request plus margin.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 300;

  // A directed row carries the request and, where it is obvious, the response
  // typed in by hand. Rows with pinned cleared use the shadow bitmap instead.
  typedef struct packed {
    bre_pkg::req_t req;
    logic          pinned;
    bre_pkg::rsp_t rsp;
  } dir_row_t;

  // A pending response, kept with the request that caused it for reporting.
  typedef struct packed {
    bre_pkg::req_t req;
    bre_pkg::rsp_t rsp;
  } pending_t;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // Fresh map: the whole range reads clear, a single bit does not read set.
    '{'{bre_pkg::MODE_TEST_CLEAR, 12'd0,    13'd4096}, 1'b1, '{1'b1, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd0,    13'd1},    1'b1, '{1'b0, 1'b0}},
    // Empty ranges answer true for both tests and change nothing.
    '{'{bre_pkg::MODE_TEST_SET,   12'd0,    13'd0},    1'b1, '{1'b1, 1'b0}},
    '{'{bre_pkg::MODE_TEST_CLEAR, 12'd4095, 13'd0},    1'b1, '{1'b1, 1'b0}},
    // Last bit of the map, then one bit past the end.
    '{'{bre_pkg::MODE_SET,        12'd4095, 13'd1},    1'b1, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd4095, 13'd1},    1'b1, '{1'b1, 1'b0}},
    '{'{bre_pkg::MODE_SET,        12'd4095, 13'd2},    1'b1, '{1'b0, 1'b1}},
    // Both fields at their maximum.
    '{'{bre_pkg::MODE_TEST_SET,   12'd4095, 13'd8191}, 1'b1, '{1'b0, 1'b1}},
    // Whole map set, then checked.
    '{'{bre_pkg::MODE_SET,        12'd0,    13'd4096}, 1'b1, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd0,    13'd4096}, 1'b1, '{1'b1, 1'b0}},
    // A two-bit hole across the first word boundary.
    '{'{bre_pkg::MODE_CLEAR,      12'd63,   13'd2},    1'b1, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd0,    13'd63},   1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_CLEAR, 12'd63,   13'd2},    1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd62,   13'd3},    1'b0, '{1'b0, 1'b0}},
    // A range ending exactly at the end of the map is legal.
    '{'{bre_pkg::MODE_CLEAR,      12'd1000, 13'd3096}, 1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_CLEAR, 12'd1000, 13'd3096}, 1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_CLEAR,      12'd0,    13'd4097}, 1'b1, '{1'b0, 1'b1}},
    '{'{bre_pkg::MODE_SET,        12'd0,    13'd0},    1'b1, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_CLEAR,      12'd2048, 13'd0},    1'b1, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_CLEAR, 12'd4095, 13'd1},    1'b0, '{1'b0, 1'b0}},
    // One word exactly, then the same word plus a bit of its neighbor.
    '{'{bre_pkg::MODE_SET,        12'd128,  13'd64},   1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd128,  13'd64},   1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_SET,   12'd127,  13'd65},   1'b0, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_CLEAR,      12'd0,    13'd4096}, 1'b1, '{1'b0, 1'b0}},
    '{'{bre_pkg::MODE_TEST_CLEAR, 12'd0,    13'd4096}, 1'b1, '{1'b1, 1'b0}}
  };

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  bre_pkg::req_t in_req    = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  bre_pkg::rsp_t out_rsp;

  // Shadow copy of the allocation bitmap, one entry per store word.
  bit [WORD_N-1:0] shadow_map [MAP_N/WORD_N];
  pending_t        pending_q [$];

  int unsigned mismatches = 0;
  int unsigned n_checked  = 0;
  int unsigned n_sent     = 0;
  int unsigned n_updates  = 0;
  int unsigned n_true     = 0;
  int unsigned n_overrun  = 0;
  int unsigned cycle_cnt  = 0;

  // Sender burst state and the last update range, used to build follow-up tests.
  int unsigned    burst_left = 0;
  bit             have_last  = 1'b0;
  bre_pkg::mode_e last_mode  = bre_pkg::MODE_SET;
  int unsigned    last_first = 0;
  int unsigned    last_count = 0;

  // Receiver stall pattern and the one long hold-off.
  int unsigned pat_kind  = 0;
  int unsigned pat_left  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  bitmap_range_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the shadow bitmap and returns the response the
  // engine must give. Out-of-range requests leave the bitmap untouched.
  function automatic bre_pkg::rsp_t apply_range(input bre_pkg::req_t r);
    int unsigned   stop;
    bre_pkg::rsp_t res;
    bit            want;
    stop = int'(r.first_bit) + int'(r.bit_count);
    res  = '0;
    if (stop > MAP_N) begin
      res.range_error = 1'b1;
      return res;
    end
    case (r.mode)
      bre_pkg::MODE_SET, bre_pkg::MODE_CLEAR: begin
        for (int unsigned n = r.first_bit; n < stop; n++) begin
          shadow_map[n / WORD_N][n % WORD_N] = (r.mode == bre_pkg::MODE_SET);
        end
      end
      default: begin
        want = (r.mode == bre_pkg::MODE_TEST_SET);
        res.test_true = 1'b1;
        for (int unsigned n = r.first_bit; n < stop; n++) begin
          if (shadow_map[n / WORD_N][n % WORD_N] != want) begin
            res.test_true = 1'b0;
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  // Offers one request, waits for its transfer, records the expected response
  // and then applies the sender's burst and gap pattern.
  task automatic send_req(input bre_pkg::req_t r, input logic pinned,
                          input bre_pkg::rsp_t pinned_rsp);
    bre_pkg::rsp_t pred;
    pending_t      entry;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready);
    pred = apply_range(r);
    entry.req = r;
    entry.rsp = pinned ? pinned_rsp : pred;
    pending_q.push_back(entry);
    n_sent++;
    if (pred.range_error) n_overrun++;
    else if (r.mode == bre_pkg::MODE_SET || r.mode == bre_pkg::MODE_CLEAR) n_updates++;
    else if (pred.test_true) n_true++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 29);
      // Most bursts end in a gap; the rest run straight into the next burst.
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        in_req   <= bre_pkg::req_t'($urandom);
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Builds one random request. About four in ten are tests on a piece of the
  // most recent update range, so that tests often answer true; a tenth run
  // past the end of the map; the rest are fresh ranges, mostly short.
  function automatic bre_pkg::req_t make_req();
    bre_pkg::req_t r;
    int unsigned   pick;
    int unsigned   first;
    int unsigned   count;
    int unsigned   off;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      first = $urandom_range(0, MAP_N - 1);
      count = $urandom_range(MAP_N + 1 - first, 8191);
      r.mode = bre_pkg::mode_e'($urandom_range(0, 3));
    end else if (pick < 50 && have_last) begin
      off   = $urandom_range(0, last_count);
      first = last_first + off;
      if (first > MAP_N - 1) first = MAP_N - 1;
      count = $urandom_range(0, last_first + last_count - first);
      r.mode = (last_mode == bre_pkg::MODE_SET) ? bre_pkg::MODE_TEST_SET
                                                : bre_pkg::MODE_TEST_CLEAR;
      if ($urandom_range(0, 3) == 0) begin
        r.mode = (r.mode == bre_pkg::MODE_TEST_SET) ? bre_pkg::MODE_TEST_CLEAR
                                                    : bre_pkg::MODE_TEST_SET;
      end
    end else begin
      first = $urandom_range(0, MAP_N - 1);
      pick  = $urandom_range(0, 99);
      if (pick < 50)      count = $urandom_range(0, 70);
      else if (pick < 80) count = $urandom_range(0, 300);
      else if (pick < 90) count = MAP_N - first;
      else if (pick < 97) count = $urandom_range(0, MAP_N - first);
      else begin
        first = $urandom_range(0, 15);
        count = MAP_N - first;
      end
      if (count > MAP_N - first) count = MAP_N - first;
      r.mode = bre_pkg::mode_e'($urandom_range(0, 3));
      if (r.mode == bre_pkg::MODE_SET || r.mode == bre_pkg::MODE_CLEAR) begin
        have_last  = 1'b1;
        last_mode  = r.mode;
        last_first = first;
        last_count = count;
      end
    end
    r.first_bit = first[bre_pkg::FIRST_W-1:0];
    r.bit_count = count[bre_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Stimulus: reset, the directed table, random traffic, then the drain.
  initial begin
    foreach (shadow_map[w]) shadow_map[w] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The engine clears its store after reset; the first transfer simply
    // waits for in_ready.
    foreach (DIR_TAB[i]) begin
      send_req(DIR_TAB[i].req, DIR_TAB[i].pinned, DIR_TAB[i].rsp);
    end
    repeat (RAND_ITEMS) begin
      send_req(make_req(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // Anything arriving now is an extra response and is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d updates, %0d tests answering true, %0d out of range.",
             n_sent, n_updates, n_true, n_overrun);
    $display("Checked %0d responses under bursty input and stalled output.", n_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Response side. The ready pattern and the response check share one process
  // so the long hold-off is triggered by an exact count of checked transfers.
  always @(posedge clk_i) begin
    pending_t exp_item;
    if (rst_ni && out_valid && out_ready) begin
      n_checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with nothing pending: test_true %0b range_error %0b",
                 $realtime, out_rsp.test_true, out_rsp.range_error);
      end else begin
        exp_item = pending_q.pop_front();
        if (out_rsp.test_true !== exp_item.rsp.test_true) begin
          mismatches++;
          $display("%0t: test_true for %s first %0d count %0d: expected %0b, got %0b",
                   $realtime, exp_item.req.mode.name(), exp_item.req.first_bit,
                   exp_item.req.bit_count, exp_item.rsp.test_true, out_rsp.test_true);
        end
        if (out_rsp.range_error !== exp_item.rsp.range_error) begin
          mismatches++;
          $display("%0t: range_error for %s first %0d count %0d: expected %0b, got %0b",
                   $realtime, exp_item.req.mode.name(), exp_item.req.first_bit,
                   exp_item.req.bit_count, exp_item.rsp.range_error, out_rsp.range_error);
        end
      end
    end

    // Once enough responses have gone by, hold ready low for a long stretch
    // while the sender keeps offering, so the engine backs up to its input.
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_checked >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_kind <= $urandom_range(0, 3);
        pat_left <= $urandom_range(5, 60);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (pat_kind)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= cycle_cnt[2];
      endcase
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d responses pending",
               $realtime, CYCLE_LIMIT, pending_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
